[rtl/core/ikv_pkg.sv]
package ikv_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_TOKEN_CHARS = 1023;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Widths fixed by the item and register formats.
    localparam int CHAR_W    = 8;
    localparam int LIMIT_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 2'd1;
    localparam logic [LIMIT_W-1:0]   NAME_LIMIT_RST  = 10'd127;
    localparam logic [LIMIT_W-1:0]   VALUE_LIMIT_RST = 10'd1023;

    // Characters the lexer reacts to.
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        K_NAME_CHAR  = 3'd0,
        K_VALUE_CHAR = 3'd1,
        K_NAME_DONE  = 3'd2,
        K_PAIR_DONE  = 3'd3,
        K_NAME_DROP  = 3'd4,
        K_ERROR      = 3'd5,
        K_INPUT_DONE = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE           = 3'd0,
        E_NAME_LONG      = 3'd1,
        E_VALUE_LONG     = 3'd2,
        E_BAD_SEP        = 3'd3,
        E_END_AFTER_NAME = 3'd4
    } t_err;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        t_kind             kind;
        t_err              code;
    } t_result;

    // All results caused by one input beat, oldest in entry 0.
    typedef struct packed {
        logic [RES_CNT_W-1:0]      n;
        t_result [MAX_RES-1:0]     res;
    } t_bundle;

    function automatic t_bundle f_emit(t_bundle b, t_kind k, logic [CHAR_W-1:0] ch,
                                       t_err e);
        t_bundle r;
        r = b;
        if (b.n < RES_CNT_W'(MAX_RES)) begin
            r.res[b.n].ch   = ch;
            r.res[b.n].kind = k;
            r.res[b.n].code = e;
            r.n             = RES_CNT_W'(b.n + 1'b1);
        end
        return r;
    endfunction

endpackage

[rtl/core/ikv_front.sv]
module ikv_front #(
    parameter int MAX_TOKEN_CHARS = ikv_pkg::DEF_MAX_TOKEN_CHARS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ikv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ikv_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [ikv_pkg::CHAR_W-1:0]     i_in_char,
    input  logic                           i_end_of_text,
    output logic                           o_wr,
    output ikv_pkg::t_bundle               o_bundle
);
    import ikv_pkg::*;

    localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [4:0] {
        LX_SKIP    = 5'b00001,
        LX_COMMENT = 5'b00010,
        LX_WORD    = 5'b00100,
        LX_QUOTE   = 5'b01000,
        LX_ESCAPE  = 5'b10000
    } t_lx;

    typedef enum logic [2:0] {
        SL_NAME  = 3'b001,
        SL_SEP   = 3'b010,
        SL_VALUE = 3'b100
    } t_slot;

    typedef struct packed {
        t_lx           lx;
        t_slot         slot;
        logic [CW-1:0] cnt;
        logic          sep;
        logic          halted;
    } t_lex;

    typedef struct packed {
        t_lex    s;
        t_bundle b;
    } t_work;

    localparam t_lex LEX_RST = '{lx: LX_SKIP, slot: SL_NAME, cnt: '0, sep: 1'b0,
                                 halted: 1'b0};

    logic [LIMIT_W-1:0] r_name_limit;
    logic [LIMIT_W-1:0] r_value_limit;
    t_lex               r_lex;
    t_lex               n_lex;
    t_work              w;
    logic [CW-1:0]      name_lim;
    logic [CW-1:0]      value_lim;
    logic               accept;

    function automatic logic [CW-1:0] f_clamp(logic [LIMIT_W-1:0] lim);
        logic [LW-1:0] ext;
        logic [LW-1:0] top;
        ext = LW'(lim);
        top = LW'(MAX_TOKEN_CHARS);
        return CW'((ext > top) ? top : ext);
    endfunction

    function automatic logic f_space(logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic t_lex f_clear(t_lex s);
        t_lex r;
        r     = s;
        r.cnt = '0;
        r.sep = 1'b0;
        r.lx  = LX_SKIP;
        return r;
    endfunction

    function automatic t_work f_take(t_work wi, logic [CHAR_W-1:0] c, logic [CW-1:0] nl,
                                     logic [CW-1:0] vl);
        t_work r;
        r = wi;
        case (wi.s.slot)
            SL_NAME: begin
                if (wi.s.cnt < nl) begin
                    r.s.cnt = CW'(wi.s.cnt + 1'b1);
                    r.b     = f_emit(r.b, K_NAME_CHAR, c, E_NONE);
                end else begin
                    r.b        = f_emit(r.b, K_ERROR, '0, E_NAME_LONG);
                    r.s.halted = 1'b1;
                end
            end
            SL_SEP: begin
                if (wi.s.cnt == '0) begin
                    r.s.cnt = CW'(1);
                    r.s.sep = (c == CH_EQUALS);
                end else begin
                    r.b        = f_emit(r.b, K_ERROR, '0, E_BAD_SEP);
                    r.s.halted = 1'b1;
                end
            end
            SL_VALUE: begin
                if (wi.s.cnt < vl) begin
                    r.s.cnt = CW'(wi.s.cnt + 1'b1);
                    r.b     = f_emit(r.b, K_VALUE_CHAR, c, E_NONE);
                end else begin
                    r.b        = f_emit(r.b, K_ERROR, '0, E_VALUE_LONG);
                    r.s.halted = 1'b1;
                end
            end
            default: begin
                r = wi;
            end
        endcase
        return r;
    endfunction

    function automatic t_work f_complete(t_work wi);
        t_work r;
        r = wi;
        case (wi.s.slot)
            SL_NAME: begin
                r.b      = f_emit(r.b, K_NAME_DONE, '0, E_NONE);
                r.s      = f_clear(r.s);
                r.s.slot = SL_SEP;
            end
            SL_SEP: begin
                if ((wi.s.cnt == CW'(1)) && wi.s.sep) begin
                    r.s      = f_clear(r.s);
                    r.s.slot = SL_VALUE;
                end else begin
                    r.b        = f_emit(r.b, K_ERROR, '0, E_BAD_SEP);
                    r.s.halted = 1'b1;
                end
            end
            SL_VALUE: begin
                r.b      = f_emit(r.b, K_PAIR_DONE, '0, E_NONE);
                r.s      = f_clear(r.s);
                r.s.slot = SL_NAME;
            end
            default: begin
                r = wi;
            end
        endcase
        return r;
    endfunction

    // Handling of a byte met between tokens.
    function automatic t_work f_skip(t_work wi, logic [CHAR_W-1:0] c, logic [CW-1:0] nl,
                                     logic [CW-1:0] vl);
        t_work r;
        r = wi;
        if (f_space(c)) begin
            r = wi;
        end else if (c == CH_HASH) begin
            r.s.lx = LX_COMMENT;
        end else if (c == CH_EQUALS) begin
            r = f_take(r, c, nl, vl);
            if (!r.s.halted) begin
                r = f_complete(r);
            end
        end else if (c == CH_DQUOTE) begin
            r.s.lx = LX_QUOTE;
        end else begin
            r = f_take(r, c, nl, vl);
            if (!r.s.halted) begin
                r.s.lx = LX_WORD;
            end
        end
        return r;
    endfunction

    assign name_lim  = f_clamp(r_name_limit);
    assign value_lim = f_clamp(r_value_limit);
    assign accept    = i_push && !i_full;

    always_comb begin
        w.s = r_lex;
        w.b = '0;
        if (i_end_of_text) begin
            if (!r_lex.halted) begin
                case (r_lex.slot)
                    SL_NAME: begin
                        if ((r_lex.lx == LX_WORD) || (r_lex.lx == LX_QUOTE) ||
                            (r_lex.lx == LX_ESCAPE)) begin
                            w.b = f_emit(w.b, K_NAME_DROP, '0, E_NONE);
                        end
                    end
                    SL_SEP: begin
                        w.b = f_emit(w.b, K_ERROR, '0, E_END_AFTER_NAME);
                    end
                    default: begin
                        w.b = f_emit(w.b, K_PAIR_DONE, '0, E_NONE);
                    end
                endcase
            end
            w.b = f_emit(w.b, K_INPUT_DONE, '0, E_NONE);
            w.s = LEX_RST;
        end else if (!r_lex.halted) begin
            case (r_lex.lx)
                LX_SKIP: begin
                    w = f_skip(w, i_in_char, name_lim, value_lim);
                end
                LX_COMMENT: begin
                    if (i_in_char == CH_LF) begin
                        w.s.lx = LX_SKIP;
                    end
                end
                LX_WORD: begin
                    if (f_space(i_in_char)) begin
                        w = f_complete(w);
                    end else if ((i_in_char == CH_HASH) || (i_in_char == CH_DQUOTE) ||
                                 (i_in_char == CH_EQUALS)) begin
                        w = f_complete(w);
                        if (!w.s.halted) begin
                            w = f_skip(w, i_in_char, name_lim, value_lim);
                        end
                    end else begin
                        w = f_take(w, i_in_char, name_lim, value_lim);
                    end
                end
                LX_QUOTE: begin
                    if (i_in_char == CH_BSLASH) begin
                        w.s.lx = LX_ESCAPE;
                    end else if (i_in_char == CH_DQUOTE) begin
                        w = f_complete(w);
                    end else begin
                        w = f_take(w, i_in_char, name_lim, value_lim);
                    end
                end
                LX_ESCAPE: begin
                    w = f_take(w, i_in_char, name_lim, value_lim);
                    if (!w.s.halted) begin
                        w.s.lx = LX_QUOTE;
                    end
                end
                default: begin
                    w.s = r_lex;
                end
            endcase
        end
        n_lex = w.s;
    end

    assign o_wr     = accept && (w.b.n != '0);
    assign o_bundle = w.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit  <= NAME_LIMIT_RST;
            r_value_limit <= VALUE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NAME_LIMIT:  r_name_limit  <= i_cfg_data;
                CFG_VALUE_LIMIT: r_value_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex <= LEX_RST;
        end else if (accept) begin
            r_lex <= n_lex;
        end
    end

    // Once halted, bytes produce nothing until the end mark.
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_lex.halted && !i_end_of_text) |-> !o_wr)
        else $error("front produced results while halted");

    // The end mark always rearms the parser.
    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_text) |=> (r_lex == LEX_RST))
        else $error("parser not rearmed after end of text");

endmodule

[rtl/core/ikv_queue.sv]
module ikv_queue #(
    parameter int QUEUE_DEPTH = ikv_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  ikv_pkg::t_bundle i_wdata,
    output logic             o_full,
    output logic             o_rd_valid,
    input  logic             i_rd,
    output ikv_pkg::t_bundle o_rdata
);
    import ikv_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_bundle       r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_wr;
    logic          do_rd;

    assign o_full     = (r_count == NW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rdata    = r_mem[r_rd_ptr];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && o_rd_valid;

    function automatic logic [AW-1:0] f_next(logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (do_rd) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (do_wr && !do_rd) begin
                r_count <= NW'(r_count + 1'b1);
            end else if (do_rd && !do_wr) begin
                r_count <= NW'(r_count - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("bundle written into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

endmodule

[rtl/core/ikv_back.sv]
module ikv_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  ikv_pkg::t_bundle                 i_q_data,
    output logic                             o_q_rd,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [ikv_pkg::CHAR_W-1:0]       o_char,
    output ikv_pkg::t_kind                   o_kind,
    output ikv_pkg::t_err                    o_code,
    output logic                             o_last
);
    import ikv_pkg::*;

    logic                 r_valid;
    t_bundle              r_bun;
    logic [RES_CNT_W-1:0] r_idx;
    logic                 last;
    logic                 take;
    t_result              cur;

    assign cur     = r_bun.res[r_idx];
    assign last    = (r_idx == RES_CNT_W'(r_bun.n - 1'b1));
    assign take    = r_valid && i_pop;
    assign o_q_rd  = i_q_valid && (!r_valid || (take && last));
    assign o_empty = !r_valid;
    assign o_char  = cur.ch;
    assign o_kind  = cur.kind;
    assign o_code  = cur.code;
    assign o_last  = last;

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_bun <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take && last) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_idx <= RES_CNT_W'(r_idx + 1'b1);
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_bun.n))
        else $error("result index outside the held bundle");

endmodule

[rtl/core/ini_key_value_tokenizer.sv]
// Streaming tokenizer for "name = value" text.
// Input channel: one beat per text byte (i_in_char), or an end mark
// (i_end_of_text). A beat is taken when push is high and full is low.
// Result channel: while empty is low the oldest result sits on o_out_char,
// o_out_kind, o_error_code and o_last_result; it is taken when pop is high.
// o_last_result marks the final result caused by one input beat.
// Configuration channel: i_cfg_valid/o_cfg_ready with a register index
// (0 name limit, 1 value limit) and data; ready is always high, and the
// registers should only be written while the block is idle.
// Results of a beat are registered in the queue, then in the output stage,
// before they reach the result ports. A beat is lexed combinationally and
// its results, up to three, go as one bundle into a queue of QUEUE_DEPTH
// entries; while pop is high the output stage drains one result per cycle,
// so an input beat is taken every cycle while beats yield one result each;
// a beat with n results holds the output until all n are popped. full rises
// at QUEUE_DEPTH bundles held, which is how a stalled receiver pushes back.
// Reset clears the parser, the queue and the output stage, and loads the
// limits with 127 and 1023.
module ini_key_value_tokenizer #(
    parameter int MAX_TOKEN_CHARS = ikv_pkg::DEF_MAX_TOKEN_CHARS,
    parameter int QUEUE_DEPTH     = ikv_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ikv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ikv_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [ikv_pkg::CHAR_W-1:0]    i_in_char,
    input  logic                          i_end_of_text,
    output logic                          empty,
    input  logic                          pop,
    output logic [ikv_pkg::CHAR_W-1:0]    o_out_char,
    output logic [2:0]                    o_out_kind,
    output logic [2:0]                    o_error_code,
    output logic                          o_last_result
);
    import ikv_pkg::*;

    logic    front_wr;
    t_bundle front_bundle;
    logic    q_full;
    logic    q_valid;
    logic    q_rd;
    t_bundle q_data;
    t_kind   out_kind;
    t_err    out_code;

    // Register writes never stall.
    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // Front end: configuration registers, lexer state and result bundling.
    ikv_front #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (q_full),
        .i_in_char     (i_in_char),
        .i_end_of_text (i_end_of_text),
        .o_wr          (front_wr),
        .o_bundle      (front_bundle)
    );

    // Bundle queue decoupling the lexer from the result receiver.
    ikv_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_wr),
        .i_wdata    (front_bundle),
        .o_full     (q_full),
        .o_rd_valid (q_valid),
        .i_rd       (q_rd),
        .o_rdata    (q_data)
    );

    // Back end: unpacks a bundle into single result beats.
    ikv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_char    (o_out_char),
        .o_kind    (out_kind),
        .o_code    (out_code),
        .o_last    (o_last_result)
    );

    assign o_out_kind   = out_kind;
    assign o_error_code = out_code;

endmodule
